### rtl/fbde_pkg.sv
// ----------------------------------------------------------------------------
// fbde_pkg
// shared types, screen geometry and pixel helpers for the page framebuffer
// draw engine
// ----------------------------------------------------------------------------
package fbde_pkg;

    localparam int SCREEN_WIDTH  = 84;
    localparam int SCREEN_HEIGHT = 48;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int COORD_W       = 10;
    localparam int ACC_W         = 12;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic [ADDR_W-1:0]         t_addr;

    typedef enum logic [3:0] {
        OP_SET_PIXEL = 4'd0,
        OP_CLR_PIXEL = 4'd1,
        OP_INV_PIXEL = 4'd2,
        OP_SET_HRUN  = 4'd3,
        OP_CLR_HRUN  = 4'd4,
        OP_SET_VRUN  = 4'd5,
        OP_CLR_VRUN  = 4'd6,
        OP_SET_CIRC  = 4'd7,
        OP_CLR_CIRC  = 4'd8,
        OP_FILL      = 4'd9,
        OP_CLEAR     = 4'd10,
        OP_READ      = 4'd11
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_SET = 2'd0,
        MODE_CLR = 2'd1,
        MODE_INV = 2'd2
    } t_mode;

    // one candidate pixel from the point generator
    typedef struct packed {
        logic   vld;
        logic   done;
        t_coord x;
        t_coord y;
    } t_pt;

    function automatic logic on_screen(t_coord x, t_coord y);
        return (x >= 0) && (x < SCREEN_WIDTH) && (y >= 0) && (y < SCREEN_HEIGHT);
    endfunction

    // byte address of a page and column, both assumed in range
    function automatic t_addr page_addr(t_addr pg, t_addr col);
        return t_addr'(pg * t_addr'(SCREEN_WIDTH)) + col;
    endfunction

    function automatic t_addr pixel_addr(t_coord x, t_coord y);
        return page_addr(t_addr'(y[COORD_W-1:3]), t_addr'(x));
    endfunction

    function automatic logic [7:0] apply_px(logic [7:0] d, logic [2:0] b, t_mode m);
        logic [7:0] mask;
        logic [7:0] res;
        mask = 8'b1 << b;
        case (m)
            MODE_SET: res = d | mask;
            MODE_CLR: res = d & ~mask;
            default:  res = d ^ mask;
        endcase
        return res;
    endfunction

endpackage

### rtl/fbde_ram.sv
// ----------------------------------------------------------------------------
// fbde_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fbde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 504,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fbde_pgen.sv
// ----------------------------------------------------------------------------
// fbde_pgen
// point generator: walks single pixels, horizontal and vertical runs and the
// eight octants of a midpoint circle, one candidate pixel per step
// ----------------------------------------------------------------------------
module fbde_pgen (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  fbde_pkg::t_opcode     i_opcode,
    input  logic signed [7:0]     i_x,
    input  logic signed [7:0]     i_y,
    input  logic [6:0]            i_len,
    input  logic                  i_next,
    output fbde_pkg::t_pt         o_pt
);

    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_RUN  = 5'b00010,
        P_CPT  = 5'b00100,
        P_CU1  = 5'b01000,
        P_CU2  = 5'b10000
    } t_pstate;

    t_pstate          r_state, n_state;
    fbde_pkg::t_coord r_x, n_x;
    fbde_pkg::t_coord r_y, n_y;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_horz, n_horz;
    logic [7:0]       r_a, n_a;
    logic [7:0]       r_b, n_b;
    fbde_pkg::t_acc   r_f, n_f;
    fbde_pkg::t_acc   r_sx, n_sx;
    fbde_pkg::t_acc   r_sy, n_sy;
    logic [2:0]       r_oct, n_oct;

    fbde_pkg::t_coord ld_x, ld_y;
    logic [7:0]       cu, cv;
    fbde_pkg::t_coord du, dv;
    fbde_pkg::t_coord cx, cy;
    logic             run_vld;

    assign ld_x = fbde_pkg::t_coord'(i_x);
    assign ld_y = fbde_pkg::t_coord'(i_y);

    // octant select: bit 2 swaps a and b, bit 0 negates x, bit 1 negates y
    always_comb begin
        cu = r_oct[2] ? r_b : r_a;
        cv = r_oct[2] ? r_a : r_b;
        du = {{(fbde_pkg::COORD_W-8){1'b0}}, cu};
        dv = {{(fbde_pkg::COORD_W-8){1'b0}}, cv};
        cx = r_x + (r_oct[0] ? -du : du);
        cy = r_y + (r_oct[1] ? -dv : dv);
    end

    assign run_vld = (r_cnt != 7'd0) &&
                     (r_horz ? (r_x < fbde_pkg::SCREEN_WIDTH)
                             : (r_y < fbde_pkg::SCREEN_HEIGHT));

    always_comb begin
        o_pt.done = (r_state == P_IDLE);
        o_pt.vld  = 1'b0;
        o_pt.x    = r_x;
        o_pt.y    = r_y;
        if (r_state == P_RUN) begin
            o_pt.vld = run_vld;
        end else if (r_state == P_CPT) begin
            o_pt.vld = 1'b1;
            o_pt.x   = cx;
            o_pt.y   = cy;
        end
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_horz  = r_horz;
        n_a     = r_a;
        n_b     = r_b;
        n_f     = r_f;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_oct   = r_oct;
        unique case (r_state)
            P_IDLE: begin
                if (i_load) begin
                    n_x   = ld_x;
                    n_y   = ld_y;
                    n_a   = 8'd0;
                    n_b   = {1'b0, i_len};
                    n_f   = fbde_pkg::t_acc'(1) - fbde_pkg::t_acc'({5'b0, i_len});
                    n_sx  = fbde_pkg::t_acc'(1);
                    n_sy  = fbde_pkg::t_acc'(0) - fbde_pkg::t_acc'({4'b0, i_len, 1'b0});
                    n_oct = 3'd0;
                    case (i_opcode) inside
                        fbde_pkg::OP_SET_PIXEL, fbde_pkg::OP_CLR_PIXEL,
                        fbde_pkg::OP_INV_PIXEL: begin
                            n_state = P_RUN;
                            n_horz  = 1'b1;
                            n_cnt   = 7'd1;
                        end
                        fbde_pkg::OP_SET_HRUN, fbde_pkg::OP_CLR_HRUN: begin
                            n_state = P_RUN;
                            n_horz  = 1'b1;
                            n_cnt   = i_len;
                        end
                        fbde_pkg::OP_SET_VRUN, fbde_pkg::OP_CLR_VRUN: begin
                            n_state = P_RUN;
                            n_horz  = 1'b0;
                            n_cnt   = i_len;
                        end
                        fbde_pkg::OP_SET_CIRC, fbde_pkg::OP_CLR_CIRC: begin
                            n_state = P_CPT;
                        end
                        default: begin
                            n_state = P_IDLE;
                        end
                    endcase
                    // a run whose start is off screen draws nothing
                    if (!fbde_pkg::on_screen(ld_x, ld_y)) begin
                        n_cnt = 7'd0;
                    end
                end
            end
            P_RUN: begin
                if (!run_vld) begin
                    n_state = P_IDLE;
                end else if (i_next) begin
                    n_cnt = r_cnt - 7'd1;
                    if (r_horz) begin
                        n_x = r_x + fbde_pkg::t_coord'(1);
                    end else begin
                        n_y = r_y + fbde_pkg::t_coord'(1);
                    end
                end
            end
            P_CPT: begin
                if (i_next) begin
                    n_oct = r_oct + 3'd1;
                    if (r_oct == 3'd7) begin
                        n_state = (r_a < r_b) ? P_CU1 : P_IDLE;
                    end
                end
            end
            P_CU1: begin
                if (!r_f[fbde_pkg::ACC_W-1]) begin
                    n_b  = r_b - 8'd1;
                    n_sy = r_sy + fbde_pkg::t_acc'(2);
                    n_f  = r_f + r_sy + fbde_pkg::t_acc'(2);
                end
                n_state = P_CU2;
            end
            P_CU2: begin
                n_a     = r_a + 8'd1;
                n_sx    = r_sx + fbde_pkg::t_acc'(2);
                n_f     = r_f + r_sx + fbde_pkg::t_acc'(2);
                n_state = P_CPT;
            end
            default: begin
                n_state = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_cnt  <= n_cnt;
        r_horz <= n_horz;
        r_a    <= n_a;
        r_b    <= n_b;
        r_f    <= n_f;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_oct  <= n_oct;
    end

endmodule

### rtl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// pixel, run and circle drawing into a page-organised 84x48 monochrome store
// reads fetch one registered byte and fill/clear write every byte in turn;
// pixels, runs and circles read and rewrite one byte per plotted point, skip
// off-screen points with no write, and a circle adds its midpoint updates
// one command at a time; busy drops in the cycle its word is strobed out and
// the word cannot be held off; the rate is set by the single read-modify-write
// port of the frame store
// reset: busy while the store is cleared, no word strobed
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [3:0]        i_opcode,
    input  logic signed [7:0] i_pos_x,
    input  logic signed [7:0] i_pos_y,
    input  logic [6:0]        i_extent,
    output logic              o_strobe,
    output logic [7:0]        o_read_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CMD   = 7'b0000010,
        S_SWEEP = 7'b0000100,
        S_GEN   = 7'b0001000,
        S_WR    = 7'b0010000,
        S_RD    = 7'b0100000,
        S_RDCAP = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    fbde_pkg::t_opcode     r_op, n_op;
    logic signed [7:0]     r_x, n_x;
    logic signed [7:0]     r_y, n_y;
    logic [6:0]            r_ext, n_ext;
    fbde_pkg::t_mode       r_mode, n_mode;
    fbde_pkg::t_addr       r_addr, n_addr;
    logic [2:0]            r_bit, n_bit;
    logic [7:0]            r_sweep_data, n_sweep_data;
    logic                  r_rsp, n_rsp;
    logic                  r_strobe, n_strobe;
    logic [7:0]            r_rdata, n_rdata;

    logic                  ram_we;
    fbde_pkg::t_addr       ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;
    logic                  pg_load, pg_next;
    fbde_pkg::t_pt         pt;
    fbde_pkg::t_addr       pt_addr;
    logic                  rd_ok;

    fbde_pgen u_pgen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (pg_load),
        .i_opcode (r_op),
        .i_x      (r_x),
        .i_y      (r_y),
        .i_len    (r_ext),
        .i_next   (pg_next),
        .o_pt     (pt)
    );

    fbde_ram #(
        .WIDTH (8),
        .DEPTH (fbde_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign pt_addr = fbde_pkg::pixel_addr(pt.x, pt.y);
    assign rd_ok   = (r_x >= 0) && (r_x < fbde_pkg::SCREEN_WIDTH) &&
                     (r_y >= 0) && (r_y < fbde_pkg::PAGE_COUNT);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_x          = r_x;
        n_y          = r_y;
        n_ext        = r_ext;
        n_mode       = r_mode;
        n_addr       = r_addr;
        n_bit        = r_bit;
        n_sweep_data = r_sweep_data;
        n_rsp        = r_rsp;
        n_strobe     = 1'b0;
        n_rdata      = r_rdata;
        ram_we       = 1'b0;
        ram_waddr    = r_addr;
        ram_wdata    = r_sweep_data;
        ram_raddr    = pt_addr;
        pg_load      = 1'b0;
        pg_next      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = fbde_pkg::t_opcode'(i_opcode);
                    n_x     = i_pos_x;
                    n_y     = i_pos_y;
                    n_ext   = i_extent;
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                unique case (r_op) inside
                    fbde_pkg::OP_SET_PIXEL, fbde_pkg::OP_SET_HRUN,
                    fbde_pkg::OP_SET_VRUN, fbde_pkg::OP_SET_CIRC: begin
                        pg_load = 1'b1;
                        n_mode  = fbde_pkg::MODE_SET;
                        n_state = S_GEN;
                    end
                    fbde_pkg::OP_CLR_PIXEL, fbde_pkg::OP_CLR_HRUN,
                    fbde_pkg::OP_CLR_VRUN, fbde_pkg::OP_CLR_CIRC: begin
                        pg_load = 1'b1;
                        n_mode  = fbde_pkg::MODE_CLR;
                        n_state = S_GEN;
                    end
                    fbde_pkg::OP_INV_PIXEL: begin
                        pg_load = 1'b1;
                        n_mode  = fbde_pkg::MODE_INV;
                        n_state = S_GEN;
                    end
                    fbde_pkg::OP_FILL, fbde_pkg::OP_CLEAR: begin
                        n_sweep_data = (r_op == fbde_pkg::OP_FILL) ? 8'hFF : 8'h00;
                        n_addr       = '0;
                        n_rsp        = 1'b1;
                        n_state      = S_SWEEP;
                    end
                    fbde_pkg::OP_READ: begin
                        if (rd_ok) begin
                            n_addr  = fbde_pkg::page_addr(
                                          fbde_pkg::t_addr'($unsigned(r_y)),
                                          fbde_pkg::t_addr'($unsigned(r_x)));
                            n_state = S_RD;
                        end else begin
                            n_strobe = 1'b1;
                            n_rdata  = 8'h00;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        n_strobe = 1'b1;
                        n_rdata  = 8'h00;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_SWEEP: begin
                ram_we = 1'b1;
                if (r_addr == fbde_pkg::t_addr'(fbde_pkg::STORE_DEPTH - 1)) begin
                    // the sweep after reset owes no word
                    n_strobe = r_rsp;
                    n_rdata  = 8'h00;
                    n_state  = S_IDLE;
                end else begin
                    n_addr = r_addr + fbde_pkg::t_addr'(1);
                end
            end
            S_GEN: begin
                if (pt.done) begin
                    n_strobe = 1'b1;
                    n_rdata  = 8'h00;
                    n_state  = S_IDLE;
                end else if (pt.vld) begin
                    pg_next = 1'b1;
                    if (fbde_pkg::on_screen(pt.x, pt.y)) begin
                        n_addr  = pt_addr;
                        n_bit   = pt.y[2:0];
                        n_state = S_WR;
                    end
                end
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_wdata = fbde_pkg::apply_px(ram_rdata, r_bit, r_mode);
                n_state   = S_GEN;
            end
            S_RD: begin
                ram_raddr = r_addr;
                n_state   = S_RDCAP;
            end
            S_RDCAP: begin
                n_strobe = 1'b1;
                n_rdata  = ram_rdata;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_addr       <= '0;
            r_sweep_data <= 8'h00;
            r_rsp        <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_sweep_data <= n_sweep_data;
            r_rsp        <= n_rsp;
            r_strobe     <= n_strobe;
        end
        r_op    <= n_op;
        r_x     <= n_x;
        r_y     <= n_y;
        r_ext   <= n_ext;
        r_mode  <= n_mode;
        r_bit   <= n_bit;
        r_rdata <= n_rdata;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_read_data = r_rdata;

endmodule

### rtl/fbde_checker.sv
// ----------------------------------------------------------------------------
// fbde_checker
// port-level checks of command accept, busy and result strobe timing
// ----------------------------------------------------------------------------
module fbde_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe
);

    // an accepted command holds busy on the following cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy
    ) else $error("busy low right after a command was accepted");

    // no word can come out in the cycle after its command is accepted
    a_no_early_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe
    ) else $error("result word one cycle after accept");

    // a word is strobed only once the engine is free again
    a_word_when_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy
    ) else $error("result word while busy");

    // one command gives one word, never two in a row
    a_single_word: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe
    ) else $error("back to back result words");

endmodule

bind page_framebuffer_draw_engine fbde_checker u_fbde_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe)
);

### test/tb_page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// tb_page_framebuffer_draw_engine
// drives pixel, run, circle, fill/clear, read and spare commands into the
// draw engine, keeps its own copy of the page store to work out every output
// word, and checks each strobed word against the oldest prediction
// ----------------------------------------------------------------------------
module tb_page_framebuffer_draw_engine;

    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_CMDS   = 1000;

    typedef struct {
        logic [3:0]        opcode;
        logic signed [7:0] pos_x;
        logic signed [7:0] pos_y;
        logic [6:0]        extent;
        logic              drain;
    } t_draw_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [3:0]        i_opcode;
    logic signed [7:0] i_pos_x;
    logic signed [7:0] i_pos_y;
    logic [6:0]        i_extent;
    logic              o_strobe;
    logic [7:0]        o_read_data;

    t_draw_cmd  cmd_q[$];
    logic [7:0] read_words_q[$];
    logic [7:0] pix_store[fbde_pkg::STORE_DEPTH];

    logic word_taken;
    int   gap_left;
    int   cmd_total;
    int   err_count;
    int   idle_cycles;

    page_framebuffer_draw_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_opcode    (i_opcode),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_extent    (i_extent),
        .o_strobe    (o_strobe),
        .o_read_data (o_read_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // ---- store predictor ----

    function automatic logic in_view(int x, int y);
        return x >= 0 && x < fbde_pkg::SCREEN_WIDTH &&
               y >= 0 && y < fbde_pkg::SCREEN_HEIGHT;
    endfunction

    function automatic void paint_dot(int x, int y, fbde_pkg::t_mode m);
        int         idx;
        logic [7:0] bit_mask;
        if (!in_view(x, y)) return;
        idx = (y / 8) * fbde_pkg::SCREEN_WIDTH + x;
        bit_mask = 8'b1 << (y % 8);
        case (m)
            fbde_pkg::MODE_SET: pix_store[idx] = pix_store[idx] | bit_mask;
            fbde_pkg::MODE_CLR: pix_store[idx] = pix_store[idx] & ~bit_mask;
            default:            pix_store[idx] = pix_store[idx] ^ bit_mask;
        endcase
    endfunction

    function automatic void paint_hrun(int x, int y, int len, fbde_pkg::t_mode m);
        if (!in_view(x, y)) return;
        for (int i = 0; i < len && x + i < fbde_pkg::SCREEN_WIDTH; i++)
            paint_dot(x + i, y, m);
    endfunction

    function automatic void paint_vrun(int x, int y, int len, fbde_pkg::t_mode m);
        if (!in_view(x, y)) return;
        for (int i = 0; i < len && y + i < fbde_pkg::SCREEN_HEIGHT; i++)
            paint_dot(x, y + i, m);
    endfunction

    // midpoint circle, eight-way symmetric outline
    function automatic void paint_ring(int cx, int cy, int r, fbde_pkg::t_mode m);
        int f;
        int ddx;
        int ddy;
        int a;
        int b;
        f = 1 - r;
        ddx = 1;
        ddy = -2 * r;
        a = 0;
        b = r;
        paint_dot(cx, cy + r, m);
        paint_dot(cx, cy - r, m);
        paint_dot(cx + r, cy, m);
        paint_dot(cx - r, cy, m);
        while (a < b) begin
            if (f >= 0) begin
                b--;
                ddy += 2;
                f += ddy;
            end
            a++;
            ddx += 2;
            f += ddx;
            paint_dot(cx + a, cy + b, m);
            paint_dot(cx - a, cy + b, m);
            paint_dot(cx + a, cy - b, m);
            paint_dot(cx - a, cy - b, m);
            paint_dot(cx + b, cy + a, m);
            paint_dot(cx - b, cy + a, m);
            paint_dot(cx + b, cy - a, m);
            paint_dot(cx - b, cy - a, m);
        end
    endfunction

    // updates the store copy and returns the word the block must strobe out
    function automatic logic [7:0] predict_word(logic [3:0] op, int x, int y, int ext);
        logic [7:0] word;
        word = 8'h00;
        case (op)
            fbde_pkg::OP_SET_PIXEL: paint_dot(x, y, fbde_pkg::MODE_SET);
            fbde_pkg::OP_CLR_PIXEL: paint_dot(x, y, fbde_pkg::MODE_CLR);
            fbde_pkg::OP_INV_PIXEL: paint_dot(x, y, fbde_pkg::MODE_INV);
            fbde_pkg::OP_SET_HRUN:  paint_hrun(x, y, ext, fbde_pkg::MODE_SET);
            fbde_pkg::OP_CLR_HRUN:  paint_hrun(x, y, ext, fbde_pkg::MODE_CLR);
            fbde_pkg::OP_SET_VRUN:  paint_vrun(x, y, ext, fbde_pkg::MODE_SET);
            fbde_pkg::OP_CLR_VRUN:  paint_vrun(x, y, ext, fbde_pkg::MODE_CLR);
            fbde_pkg::OP_SET_CIRC:  paint_ring(x, y, ext, fbde_pkg::MODE_SET);
            fbde_pkg::OP_CLR_CIRC:  paint_ring(x, y, ext, fbde_pkg::MODE_CLR);
            fbde_pkg::OP_FILL:      foreach (pix_store[i]) pix_store[i] = 8'hFF;
            fbde_pkg::OP_CLEAR:     foreach (pix_store[i]) pix_store[i] = 8'h00;
            fbde_pkg::OP_READ: begin
                if (x >= 0 && x < fbde_pkg::SCREEN_WIDTH &&
                    y >= 0 && y < fbde_pkg::PAGE_COUNT)
                    word = pix_store[y * fbde_pkg::SCREEN_WIDTH + x];
            end
            default: ;
        endcase
        return word;
    endfunction

    // ---- driver ----

    always @(negedge i_clk) begin
        t_draw_cmd nxt;
        logic      go;
        go = start;
        if (!i_rst_n) begin
            go = 1'b0;
        end else if (!start || word_taken) begin
            go = 1'b0;
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (cmd_q.size() > 0
                         && !(cmd_q[0].drain && read_words_q.size() > 0)) begin
                nxt = cmd_q.pop_front();
                i_opcode <= nxt.opcode;
                i_pos_x  <= nxt.pos_x;
                i_pos_y  <= nxt.pos_y;
                i_extent <= nxt.extent;
                go = 1'b1;
                // every hundred commands, a stretch of thirty back to back
                gap_left <= (cmd_total % 100 < 30) ? 0 : $urandom_range(0, 10);
                cmd_total <= cmd_total + 1;
            end
        end
        start <= go;
    end

    // ---- monitor and checker ----

    always @(posedge i_clk) begin
        logic [7:0] want;
        logic       took;
        took = i_rst_n && start && !busy;
        word_taken <= took;
        if (i_rst_n && o_strobe) begin
            if (read_words_q.size() == 0) begin
                if (err_count < 10)
                    $display("unexpected word: read_data=%02h", o_read_data);
                err_count++;
            end else begin
                want = read_words_q.pop_front();
                if (o_read_data !== want) begin
                    if (err_count < 10)
                        $display("read_data mismatch: expected %02h, got %02h",
                                 want, o_read_data);
                    err_count++;
                end
            end
        end
        // result of a command accepted now is pushed after the strobe check
        if (took)
            read_words_q.push_back(predict_word(i_opcode, int'(i_pos_x),
                                                int'(i_pos_y), int'(i_extent)));
        if (took || (i_rst_n && o_strobe)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---- stimulus ----

    task automatic queue_cmd(logic [3:0] op, int x, int y, int ext, logic drain = 1'b0);
        t_draw_cmd c;
        c.opcode = op;
        c.pos_x  = 8'(x);
        c.pos_y  = 8'(y);
        c.extent = 7'(ext);
        c.drain  = drain;
        cmd_q.push_back(c);
    endtask

    initial begin
        int         sel;
        logic [3:0] op;
        int         x;
        int         y;
        int         ext;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_opcode    = 4'h0;
        i_pos_x     = 8'sh00;
        i_pos_y     = 8'sh00;
        i_extent    = 7'h00;
        word_taken  = 1'b0;
        gap_left    = 0;
        cmd_total   = 0;
        err_count   = 0;
        idle_cycles = 0;
        foreach (pix_store[i]) pix_store[i] = 8'h00;

        // directed: corners, off-screen pixels, clipped and skipped runs
        queue_cmd(fbde_pkg::OP_READ, 0, 0, 0);
        queue_cmd(fbde_pkg::OP_SET_PIXEL, 0, 0, 0);
        queue_cmd(fbde_pkg::OP_SET_PIXEL, fbde_pkg::SCREEN_WIDTH - 1,
                  fbde_pkg::SCREEN_HEIGHT - 1, 0);
        queue_cmd(fbde_pkg::OP_INV_PIXEL, 2, 9, 0);
        queue_cmd(fbde_pkg::OP_READ, fbde_pkg::SCREEN_WIDTH - 1,
                  fbde_pkg::PAGE_COUNT - 1, 0);
        queue_cmd(fbde_pkg::OP_INV_PIXEL, fbde_pkg::SCREEN_WIDTH - 1,
                  fbde_pkg::SCREEN_HEIGHT - 1, 0);
        queue_cmd(fbde_pkg::OP_CLR_PIXEL, 0, 0, 0);
        queue_cmd(fbde_pkg::OP_SET_PIXEL, -128, -128, 0);
        queue_cmd(fbde_pkg::OP_SET_PIXEL, 127, 127, 0);
        queue_cmd(fbde_pkg::OP_SET_PIXEL, fbde_pkg::SCREEN_WIDTH, 5, 0);
        queue_cmd(fbde_pkg::OP_SET_PIXEL, 5, fbde_pkg::SCREEN_HEIGHT, 0);
        queue_cmd(fbde_pkg::OP_SET_HRUN, fbde_pkg::SCREEN_WIDTH - 4, 10, 127);
        queue_cmd(fbde_pkg::OP_SET_HRUN, -5, 10, 20);
        queue_cmd(fbde_pkg::OP_SET_HRUN, 10, 10, 0);
        queue_cmd(fbde_pkg::OP_READ, fbde_pkg::SCREEN_WIDTH - 1, 1, 0);
        queue_cmd(fbde_pkg::OP_SET_VRUN, 10, 40, 127);
        queue_cmd(fbde_pkg::OP_CLR_VRUN, 10, 44, 2);
        queue_cmd(fbde_pkg::OP_SET_CIRC, 42, 24, 20);
        queue_cmd(fbde_pkg::OP_SET_CIRC, 42, 24, 0);
        queue_cmd(fbde_pkg::OP_CLR_CIRC, 42, 24, 127);
        queue_cmd(fbde_pkg::OP_CLR_HRUN, 0, 10, 127);
        queue_cmd(fbde_pkg::OP_FILL, 0, 0, 0, 1'b1);
        queue_cmd(fbde_pkg::OP_READ, fbde_pkg::SCREEN_WIDTH, 0, 0);
        queue_cmd(fbde_pkg::OP_READ, 0, fbde_pkg::PAGE_COUNT, 0);
        queue_cmd(fbde_pkg::OP_CLEAR, 0, 0, 0);
        for (int k = int'(fbde_pkg::OP_READ) + 1; k < 16; k++)
            queue_cmd(4'(k), 50, 3, 127);

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                op = 4'(int'(fbde_pkg::OP_SET_PIXEL) + $urandom_range(0, 2));
            else if (sel < 55)
                op = 4'(int'(fbde_pkg::OP_SET_HRUN) + $urandom_range(0, 3));
            else if (sel < 63)
                op = 4'(int'(fbde_pkg::OP_SET_CIRC) + $urandom_range(0, 1));
            else if (sel < 65)
                op = 4'(int'(fbde_pkg::OP_FILL) + $urandom_range(0, 1));
            else if (sel < 67)
                op = 4'(int'(fbde_pkg::OP_READ) + $urandom_range(1, 4));
            else
                op = fbde_pkg::OP_READ;
            // mostly near the screen, now and then anywhere in the signed range
            if ($urandom_range(0, 99) < 85)
                x = $urandom_range(0, fbde_pkg::SCREEN_WIDTH + 7) - 4;
            else
                x = $urandom_range(0, 255);
            if ($urandom_range(0, 99) >= 85)
                y = $urandom_range(0, 255);
            else if (op == fbde_pkg::OP_READ)
                y = $urandom_range(0, fbde_pkg::PAGE_COUNT + 1) - 1;
            else
                y = $urandom_range(0, fbde_pkg::SCREEN_HEIGHT + 7) - 4;
            if ($urandom_range(0, 99) < 85) ext = $urandom_range(0, 24);
            else                            ext = $urandom_range(0, 127);
            queue_cmd(op, x, y, ext, $urandom_range(0, 49) == 0);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() > 0 || start || read_words_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (err_count == 0 && read_words_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### page_framebuffer_draw_engine.f
rtl/fbde_pkg.sv
rtl/fbde_ram.sv
rtl/fbde_pgen.sv
rtl/page_framebuffer_draw_engine.sv
rtl/fbde_checker.sv
test/tb_page_framebuffer_draw_engine.sv
